// ===== hw/rtl/tea_block_cipher_top_assert.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef TEA_BLOCK_CIPHER_TOP_ASSERT_SVH
`define TEA_BLOCK_CIPHER_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define TEA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled in reset.
`define TEA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/tea_pkg.sv =====
`default_nettype none

package tea_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned RoundsDflt = 32;

  localparam logic [WordW-1:0] Delta = 32'h9e37_79b9;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] KeyWord0Idx = 4'd0;
  localparam logic [CfgIdxW-1:0] KeyWord1Idx = 4'd1;
  localparam logic [CfgIdxW-1:0] KeyWord2Idx = 4'd2;
  localparam logic [CfgIdxW-1:0] KeyWord3Idx = 4'd3;

  typedef struct packed {
    logic [WordW-1:0] k0;
    logic [WordW-1:0] k1;
    logic [WordW-1:0] k2;
    logic [WordW-1:0] k3;
  } tea_key_t;

  // One beat moving down the cell chain. x is the half being updated next,
  // y the half feeding the mix.
  typedef struct packed {
    logic             valid;
    logic             dec;
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
  } tea_beat_t;

  // delta * n mod 2^32, evaluated at elaboration
  function automatic logic [WordW-1:0] round_sum(input int unsigned n);
    logic [63:0] p;
    p = 64'(Delta) * 64'(n);
    return p[WordW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tea_cell.sv =====
`default_nettype none

// One half round: x +/- mix(y), then halves swap for the next cell.
module tea_cell #(
  parameter logic [tea_pkg::WordW-1:0] SUM_ENC  = tea_pkg::Delta,
  parameter logic [tea_pkg::WordW-1:0] SUM_DEC  = tea_pkg::Delta,
  parameter bit                        KEY_SWAP = 1'b0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tea_pkg::tea_beat_t  beat_i,
  input  wire tea_pkg::tea_key_t   key_i,
  output tea_pkg::tea_beat_t       beat_o
);

  logic                      valid_q;
  logic                      dec_q;
  logic [tea_pkg::WordW-1:0] x_q, x_d;
  logic [tea_pkg::WordW-1:0] y_q;

  logic [tea_pkg::WordW-1:0] sum, ka, kb, mix;
  logic                      hi_keys;

  always_comb begin
    sum     = beat_i.dec ? SUM_DEC : SUM_ENC;
    hi_keys = beat_i.dec ^ KEY_SWAP;
    ka      = hi_keys ? key_i.k2 : key_i.k0;
    kb      = hi_keys ? key_i.k3 : key_i.k1;
    mix     = ((beat_i.y << 4) + ka) ^ (beat_i.y + sum) ^ ((beat_i.y >> 5) + kb);
    x_d     = beat_i.dec ? (beat_i.x - mix) : (beat_i.x + mix);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= beat_i.valid;
    end
  end

  // swap: updated half becomes the mix source for the next cell
  always_ff @(posedge clk_i) begin
    dec_q <= beat_i.dec;
    x_q   <= beat_i.y;
    y_q   <= x_d;
  end

  assign beat_o = '{valid: valid_q, dec: dec_q, x: x_q, y: y_q};

endmodule

`default_nettype wire

// ===== hw/rtl/tea_block_cipher_top.sv =====
// TEA block cipher, ROUND_COUNT rounds (default 32), fully unrolled cell chain.
// Pipeline: one cell per half round, each cell one register stage.
// Throughput: one block per cycle; busy stays low, the receiver cannot stall.
// Reset (rst_ni low, async): clears the beat valid chain and all key words.
`default_nettype none

`include "tea_block_cipher_top_assert.svh"

module tea_block_cipher_top #(
  parameter int unsigned ROUND_COUNT = tea_pkg::RoundsDflt
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // block command
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        operation_i,
  input  wire logic [tea_pkg::WordW-1:0]   first_word_i,
  input  wire logic [tea_pkg::WordW-1:0]   second_word_i,
  // result beat, one cycle strobe
  output logic                             done_o,
  output logic [tea_pkg::WordW-1:0]        out_first_word_o,
  output logic [tea_pkg::WordW-1:0]        out_second_word_o,
  // key register writes
  input  wire logic                        cfg_we_i,
  input  wire logic [tea_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [tea_pkg::WordW-1:0]   cfg_wdata_i
);

  localparam int unsigned Stages = 2 * ROUND_COUNT;

  // ---------------------------------------------------------------------------
  // Key words
  // ---------------------------------------------------------------------------
  tea_pkg::tea_key_t key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tea_pkg::KeyWord0Idx: key_q.k0 <= cfg_wdata_i;
        tea_pkg::KeyWord1Idx: key_q.k1 <= cfg_wdata_i;
        tea_pkg::KeyWord2Idx: key_q.k2 <= cfg_wdata_i;
        tea_pkg::KeyWord3Idx: key_q.k3 <= cfg_wdata_i;
        default: ; // unmapped index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------------
  // Every stage can take a new beat each cycle, so nothing ever holds off.
  assign busy = 1'b0;

  tea_pkg::tea_beat_t beat [Stages+1];

  // Encrypt updates the first half first, decrypt the second half first, so
  // the entry orders the halves as (target, source).
  assign beat[0] = '{
    valid: start && !busy,
    dec:   operation_i,
    x:     operation_i ? second_word_i : first_word_i,
    y:     operation_i ? first_word_i  : second_word_i
  };

  // Cell g works on round g/2, half g%2. Round sums are fixed per cell:
  // encrypt uses delta*(r+1), decrypt delta*(ROUND_COUNT-r).
  for (genvar g = 0; g < Stages; g++) begin : g_cell
    tea_cell #(
      .SUM_ENC (tea_pkg::round_sum(g / 2 + 1)),
      .SUM_DEC (tea_pkg::round_sum(ROUND_COUNT - g / 2)),
      .KEY_SWAP(bit'(g % 2))
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .beat_i(beat[g]),
      .key_i (key_q),
      .beat_o(beat[g+1])
    );
  end

  // Even number of swaps: halves come out in entry order.
  assign done_o            = beat[Stages].valid;
  assign out_first_word_o  = beat[Stages].dec ? beat[Stages].y : beat[Stages].x;
  assign out_second_word_o = beat[Stages].dec ? beat[Stages].x : beat[Stages].y;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TEA_ASSERT_NEXT(a_entry_valid, clk_i, rst_ni, start && !busy, beat[1].valid)
  `TEA_ASSERT_IMPL(a_done_has_start, clk_i, rst_ni, done_o, $past(start, Stages))
  `TEA_ASSERT_IMPL(a_done_op_kept, clk_i, rst_ni, done_o, beat[Stages].dec == $past(operation_i, Stages))

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

// Block-level bench for the unrolled TEA core.
// Blocks go in on start/busy and come back on the done_o strobe.
// The core cannot be stalled on the result side. A local cipher model predicts
// every result when its block is accepted. The checker pops predictions in order
// and compares them word by word.
module tb;

  localparam int unsigned WordW         = tea_pkg::WordW;
  localparam int unsigned CfgIdxW       = tea_pkg::CfgIdxW;
  localparam int unsigned Rounds        = tea_pkg::RoundsDflt;
  localparam int unsigned LatencyCycles = 2 * Rounds;   // one cell per half round
  localparam int unsigned TimeoutCycles = 200_000;
  localparam int unsigned KeyCount      = 4;

  // block operation codes
  localparam bit OpEncrypt = 1'b0;
  localparam bit OpDecrypt = 1'b1;

  typedef struct packed {
    logic [WordW-1:0] first;
    logic [WordW-1:0] second;
  } block_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               start         = 1'b0;
  logic               busy;
  logic               operation_i   = OpEncrypt;
  logic [WordW-1:0]   first_word_i  = '0;
  logic [WordW-1:0]   second_word_i = '0;
  logic               done_o;
  logic [WordW-1:0]   out_first_word_o;
  logic [WordW-1:0]   out_second_word_o;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [WordW-1:0]   cfg_wdata_i   = '0;

  // Shadow copy of the key registers, kept in step with every write
  logic [WordW-1:0] key_q [KeyCount];
  // Ciphertext/plaintext blocks predicted but not yet seen on the result port
  block_t           pending_blocks [$];
  block_t           head_block;
  int unsigned      error_count = 0;

  tea_block_cipher_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .operation_i       (operation_i),
    .first_word_i      (first_word_i),
    .second_word_i     (second_word_i),
    .done_o            (done_o),
    .out_first_word_o  (out_first_word_o),
    .out_second_word_o (out_second_word_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Cipher model
  // ---------------------------------------------------------------------------

  // Feistel half-round function: shifted copies of x plus a key pair, xor'ed
  // with x plus the running round sum.
  function automatic logic [WordW-1:0] half_mix(input logic [WordW-1:0] x,
                                                input logic [WordW-1:0] s,
                                                input logic [WordW-1:0] ka,
                                                input logic [WordW-1:0] kb);
    return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
  endfunction

  // Full 32-round pass, all sums wrap mod 2^32. Decrypt starts at
  // delta*rounds and walks the rounds backwards.
  function automatic block_t tea_cipher(input bit op, input logic [WordW-1:0] a_in,
                                        input logic [WordW-1:0] b_in);
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] sum;
    a = a_in;
    b = b_in;
    if (op == OpEncrypt) begin
      sum = '0;
      for (int unsigned r = 0; r < Rounds; r++) begin
        sum = sum + tea_pkg::Delta;
        a   = a + half_mix(b, sum, key_q[0], key_q[1]);
        b   = b + half_mix(a, sum, key_q[2], key_q[3]);
      end
    end else begin
      sum = tea_pkg::Delta * Rounds;
      for (int unsigned r = 0; r < Rounds; r++) begin
        b   = b - half_mix(a, sum, key_q[2], key_q[3]);
        a   = a - half_mix(b, sum, key_q[0], key_q[1]);
        sum = sum - tea_pkg::Delta;
      end
    end
    return {a, b};
  endfunction

  // Data words: mostly random, with a fair share of all-zero, all-one,
  // one-hot and one-cold values.
  function automatic logic [WordW-1:0] pick_word();
    logic [WordW-1:0] one_hot;
    one_hot = 32'h1 << $urandom_range(WordW - 1);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. All of them are entered and left at a rising edge.
  // ---------------------------------------------------------------------------

  // One register write; cfg_we_i stays high for the next write, the caller
  // drops it.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      tea_pkg::KeyWord0Idx: key_q[0] = data;
      tea_pkg::KeyWord1Idx: key_q[1] = data;
      tea_pkg::KeyWord2Idx: key_q[2] = data;
      tea_pkg::KeyWord3Idx: key_q[3] = data;
      default: ;    // unmapped index, the core must ignore it
    endcase
  endtask

  // Whole key, followed by some writes to unmapped indexes that must not land.
  task automatic load_key(input logic [WordW-1:0] k0, input logic [WordW-1:0] k1,
                          input logic [WordW-1:0] k2, input logic [WordW-1:0] k3,
                          input int unsigned stray_writes);
    write_reg(tea_pkg::KeyWord0Idx, k0);
    write_reg(tea_pkg::KeyWord1Idx, k1);
    write_reg(tea_pkg::KeyWord2Idx, k2);
    write_reg(tea_pkg::KeyWord3Idx, k3);
    repeat (stray_writes)
      write_reg(CfgIdxW'($urandom_range(2**CfgIdxW - 1, tea_pkg::KeyWord3Idx + 1)),
                $urandom);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one block and hold it until the core takes it. start stays high so
  // back-to-back calls stream one block per cycle.
  task automatic send_block(input bit op, input logic [WordW-1:0] a,
                            input logic [WordW-1:0] b);
    start         <= 1'b1;
    operation_i   <= op;
    first_word_i  <= a;
    second_word_i <= b;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_blocks.push_back(tea_cipher(op, a, b));
  endtask

  // Sender gap with junk on the data lines
  task automatic sender_gap(input int unsigned cycles);
    if (cycles > 0) begin
      start         <= 1'b0;
      operation_i   <= 1'($urandom);
      first_word_i  <= $urandom;
      second_word_i <= $urandom;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Stop sending and let the pipe empty out
  task automatic wait_drained();
    if (start)
      start <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: done_o is a one-cycle strobe, sampled at the edge that
  // closes the beat.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_blocks.size() == 0) begin
        $error("result beat with no block pending: %h %h",
               out_first_word_o, out_second_word_o);
        error_count++;
      end else begin
        head_block = pending_blocks.pop_front();
        if (out_first_word_o !== head_block.first) begin
          $error("out_first_word: expected %h, got %h", head_block.first, out_first_word_o);
          error_count++;
        end
        if (out_second_word_o !== head_block.second) begin
          $error("out_second_word: expected %h, got %h", head_block.second,
                 out_second_word_o);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // All-zero key straight out of reset, extreme data, both directions,
  // streamed back to back.
  task automatic test_reset_key();
    send_block(OpEncrypt, '0, '0);
    send_block(OpEncrypt, '1, '1);
    send_block(OpDecrypt, '0, '0);
    send_block(OpDecrypt, '1, '1);
    send_block(OpEncrypt, 32'h8000_0000, 32'h0000_0001);
    send_block(OpDecrypt, 32'h0000_0001, 32'h8000_0000);
    wait_drained();
  endtask

  // All-one key, then a checkerboard key with stray writes to unmapped
  // indexes; ends with an encrypt/decrypt round trip.
  task automatic test_key_extremes();
    block_t cipher;
    load_key('1, '1, '1, '1, 0);
    send_block(OpEncrypt, '0, '1);
    send_block(OpDecrypt, '1, '0);
    send_block(OpEncrypt, 32'hffff_fffe, 32'h7fff_ffff);
    send_block(OpDecrypt, 32'h5555_5555, 32'haaaa_aaaa);
    wait_drained();
    load_key(32'ha5a5_a5a5, 32'h5a5a_5a5a, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 8);
    send_block(OpEncrypt, '0, '0);
    send_block(OpDecrypt, '1, '1);
    send_block(OpEncrypt, 32'h0123_4567, 32'h89ab_cdef);
    cipher = tea_cipher(OpEncrypt, 32'h0123_4567, 32'h89ab_cdef);
    send_block(OpDecrypt, cipher.first, cipher.second);    // must give plaintext back
    wait_drained();
  endtask

  // Random blocks under a fresh random key. Before idle_pct percent of the
  // blocks the sender pauses, usually briefly but sometimes across the whole pipe,
  // and halfway through it holds off until every result is back.
  task automatic test_random_blocks(input int unsigned items, input int unsigned idle_pct);
    load_key($urandom, $urandom, $urandom, $urandom, $urandom_range(3));
    for (int unsigned i = 0; i < items; i++) begin
      if ($urandom_range(99) < idle_pct)
        sender_gap(($urandom_range(9) == 0) ? $urandom_range(LatencyCycles + 8, 1)
                                            : $urandom_range(4, 1));
      if (i == items / 2)
        wait_drained();
      send_block(1'($urandom_range(1)), pick_word(), pick_word());
    end
    wait_drained();
  endtask

  initial begin
    foreach (key_q[i]) key_q[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_key();
    test_key_extremes();
    test_random_blocks(220, 0);     // full rate
    test_random_blocks(220, 58);    // sparse sender
    test_random_blocks(210, 7);     // light gaps

    // catch late or extra beats
    repeat (LatencyCycles + 8) @(posedge clk_i);
    if (error_count == 0)
      $display("** tea_block_cipher_top: PASSED **");
    else
      $display("** tea_block_cipher_top: FAILED **");
    $finish;
  end

  // Hang guard
  initial begin
    #(TimeoutCycles * 10);
    $display("** tea_block_cipher_top: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tea_pkg.sv
hw/rtl/tea_cell.sv
hw/rtl/tea_block_cipher_top.sv
tb/sv/tb.sv
